>>> hdl/bchm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchm_pkg: shared types and constants
// Poll and result payloads, chord tracker status and register map for the
// button chord hold mode controller.
// ----------------------------------------------------------------------------
package bchm_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;

  localparam logic [CFG_W-1:0] HOLD_MS_RESET        = 16'd3000;
  localparam logic [CFG_W-1:0] TRIPLE_HOLD_MS_RESET = 16'd5000;
  localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RESET   = 16'd10000;

  typedef enum logic [1:0] {
    REG_HOLD_MS        = 2'd0,
    REG_TRIPLE_HOLD_MS = 2'd1,
    REG_IDLE_TIMEOUT   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              up_pressed;
    logic              down_pressed;
    logic              stop_pressed;
    logic              user_activity;
  } poll_t;

  typedef struct packed {
    logic time_settings_on;
    logic alarm_settings_on;
    logic view_alarms_on;
    logic save_time_req;
    logic new_alarm_req;
    logic alarm_index_clear;
    logic blink_restart;
    logic display_refresh;
  } result_t;

  typedef struct packed {
    logic holding_next;
    logic fire;
  } chord_status_t;

endpackage

>>> hdl/bchm_chord.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchm_chord: one chord hold tracker
// Records the hold start when the chord appears and fires once when it has
// been held for the required time.
// ----------------------------------------------------------------------------
module bchm_chord (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          present,
  input  logic [bchm_pkg::TIME_W-1:0]   now_ms,
  input  logic [bchm_pkg::CFG_W-1:0]    need,
  output bchm_pkg::chord_status_t       status
);
  import bchm_pkg::*;

  logic              holding;
  logic              holding_next;
  logic              fired;
  logic              fired_next;
  logic [TIME_W-1:0] start;
  logic [TIME_W-1:0] start_next;
  logic [TIME_W-1:0] elapsed;
  logic              ripe;
  logic              fire;

  assign elapsed = now_ms - start;
  assign ripe    = elapsed >= {{(TIME_W-CFG_W){1'b0}}, need};

  always_comb begin
    holding_next = holding;
    fired_next   = fired;
    start_next   = start;
    fire         = 1'b0;
    if (!present) begin
      holding_next = 1'b0;
    end else if (!holding) begin
      holding_next = 1'b1;
      fired_next   = 1'b0;
      start_next   = now_ms;
    end else begin
      fire       = !fired && ripe;
      fired_next = fired || fire;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding <= 1'b0;
      fired   <= 1'b0;
    end else if (en) begin
      holding <= holding_next;
      fired   <= fired_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      start <= start_next;
    end
  end

  assign status.holding_next = holding_next;
  assign status.fire         = fire;

endmodule

>>> hdl/button_chord_hold_mode_controller.sv
`timescale 1ns / 1ps
// Throughput: one poll per cycle while out_stall does not hold the result;
// the input register and the result register part the two sides, and the
// mode and chord state update once per poll.
// Reset: all modes off, chord trackers and last activity cleared, hold times
// 3000 and 5000 ms, idle timeout 10000 ms. No clearing pass.
// ----------------------------------------------------------------------------
// button_chord_hold_mode_controller: top level
// Tracks the stop, up-down and triple button chords, toggles the settings
// and view modes, applies the idle timeout and issues request pulses.
// ----------------------------------------------------------------------------
module button_chord_hold_mode_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bchm_pkg::poll_t   in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bchm_pkg::result_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import bchm_pkg::*;

  logic [CFG_W-1:0]  hold_ms;
  logic [CFG_W-1:0]  triple_hold_ms;
  logic [CFG_W-1:0]  idle_timeout_ms;
  reg_idx_t          reg_idx;
  logic              cfg_write;

  poll_t             poll;
  logic              poll_valid;
  logic              accept;
  logic              adv;

  logic [TIME_W-1:0] last_activity;
  logic [TIME_W-1:0] last_activity_next;
  logic              time_mode;
  logic              alarm_mode;
  logic              view_mode;
  logic              time_mode_next;
  logic              alarm_mode_next;
  logic              view_mode_next;

  chord_status_t     stop_st;
  chord_status_t     pair_st;
  chord_status_t     triple_st;
  logic              stop_present;
  logic              pair_present;
  logic              triple_present;
  logic [TIME_W-1:0] idle_elapsed;
  logic              idle_ok;
  logic              time_mid;
  logic              alarm_mid;
  logic              time_to;
  logic              alarm_to;
  result_t           res;

  // configuration port
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms         <= HOLD_MS_RESET;
      triple_hold_ms  <= TRIPLE_HOLD_MS_RESET;
      idle_timeout_ms <= IDLE_TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_HOLD_MS:        hold_ms         <= pwdata[CFG_W-1:0];
        REG_TRIPLE_HOLD_MS: triple_hold_ms  <= pwdata[CFG_W-1:0];
        REG_IDLE_TIMEOUT:   idle_timeout_ms <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HOLD_MS:        prdata = {16'd0, hold_ms};
      REG_TRIPLE_HOLD_MS: prdata = {16'd0, triple_hold_ms};
      REG_IDLE_TIMEOUT:   prdata = {16'd0, idle_timeout_ms};
      default:            prdata = 32'd0;
    endcase
  end

  // handshake
  assign adv      = poll_valid && (!out_valid || !out_stall);
  assign in_stall = poll_valid && !adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (accept) begin
      poll_valid <= 1'b1;
    end else if (adv) begin
      poll_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      poll <= in_data;
    end
  end

  // chord trackers
  assign stop_present   = !view_mode && poll.stop_pressed && !poll.up_pressed &&
                          !poll.down_pressed;
  assign pair_present   = !view_mode && poll.up_pressed && poll.down_pressed &&
                          !poll.stop_pressed;
  assign triple_present = poll.up_pressed && poll.down_pressed && poll.stop_pressed;

  bchm_chord u_stop (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .present (stop_present),
    .now_ms  (poll.now_ms),
    .need    (hold_ms),
    .status  (stop_st)
  );

  bchm_chord u_pair (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .present (pair_present),
    .now_ms  (poll.now_ms),
    .need    (hold_ms),
    .status  (pair_st)
  );

  bchm_chord u_triple (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .present (triple_present),
    .now_ms  (poll.now_ms),
    .need    (triple_hold_ms),
    .status  (triple_st)
  );

  // mode update and idle timeout
  always_comb begin
    if (poll.user_activity || stop_st.fire || pair_st.fire || triple_st.fire) begin
      last_activity_next = poll.now_ms;
    end else begin
      last_activity_next = last_activity;
    end
    idle_elapsed = poll.now_ms - last_activity_next;
    idle_ok      = idle_elapsed >= {{(TIME_W-CFG_W){1'b0}}, idle_timeout_ms};

    alarm_mid      = stop_st.fire ? !alarm_mode : alarm_mode;
    time_mid       = pair_st.fire ? !time_mode : time_mode;
    view_mode_next = triple_st.fire ? !view_mode : view_mode;

    time_to  = time_mid && !pair_st.holding_next && idle_ok;
    alarm_to = alarm_mid && !stop_st.holding_next && idle_ok;

    time_mode_next  = time_mid && !time_to;
    alarm_mode_next = alarm_mid && !alarm_to;
  end

  always_comb begin
    res.time_settings_on  = time_mode_next;
    res.alarm_settings_on = alarm_mode_next;
    res.view_alarms_on    = view_mode_next;
    res.save_time_req     = (pair_st.fire && time_mode) || time_to;
    res.new_alarm_req     = stop_st.fire && !alarm_mode;
    res.alarm_index_clear = triple_st.fire && !view_mode;
    res.blink_restart     = stop_st.fire || pair_st.fire;
    res.display_refresh   = stop_st.fire || pair_st.fire || triple_st.fire ||
                            time_to || alarm_to;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_activity <= '0;
      time_mode     <= 1'b0;
      alarm_mode    <= 1'b0;
      view_mode     <= 1'b0;
    end else if (adv) begin
      last_activity <= last_activity_next;
      time_mode     <= time_mode_next;
      alarm_mode    <= alarm_mode_next;
      view_mode     <= view_mode_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res;
    end
  end

  a_new_alarm_enters : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.new_alarm_req |-> out_data.alarm_settings_on)
    else $error("new alarm request without alarm settings mode");

  a_save_exits : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.save_time_req |-> !out_data.time_settings_on)
    else $error("time save requested while time settings mode stays on");

  a_index_clear_view : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.alarm_index_clear |-> out_data.view_alarms_on)
    else $error("alarm index clear without entering view mode");

  a_blink_refresh : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.blink_restart |-> out_data.display_refresh)
    else $error("blink restart without display refresh");

  a_mode_tracks_result : assert property (@(posedge clk) disable iff (rst)
    $past(adv) |-> out_data.view_alarms_on == view_mode)
    else $error("result view mode differs from held view mode");

endmodule
